// ===== src/pcgbg_pkg.sv =====
// Shared types and constants for the PCG-XSH-RR 64/32 bounded generator.
// Holds the controller/datapath command and status structs and the register map.
// No dependencies.
package pcgbg_pkg;

   // Configuration register map.
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STREAM = 8'd1;

   // LCG multiplier 6364136223846793005, split into 32-bit halves.
   localparam logic [31:0] PCG_MULT_LO = 32'h4C95_7F2D;
   localparam logic [31:0] PCG_MULT_HI = 32'h5851_F42D;

   // Operand pair for the shared 32x32 multiplier.
   typedef enum logic [1:0] {
      MUL_LL,
      MUL_HL,
      MUL_LH
   } mul_sel_type;

   // Accumulator operation for the 64-bit product.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_HI
   } acc_op_type;

   // Dividend source for the remainder unit.
   typedef enum logic {
      DIV_THR,
      DIV_DRAW
   } div_sel_type;

   // Source of the result word.
   typedef enum logic [1:0] {
      OUT_DRAW,
      OUT_REM,
      OUT_ZERO
   } out_sel_type;

   typedef struct packed {
      logic        cfg_wr_seed;
      logic        cfg_wr_stream;
      logic        seed_init;
      logic        seed_add;
      logic        bound_load;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        commit;
      logic        div_start;
      div_sel_type div_sel;
      logic        thr_load;
      logic        out_load;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic draw_ge_thr;
      logic div_busy;
   } dp_status_type;

endpackage

// ===== src/pcgbg_rem.sv =====
// Iterative 32-bit remainder unit, restoring, two quotient bits per cycle.
// Depends on nothing; instantiated by pcgbg_datapath.
module pcgbg_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] remainder
);

   localparam int unsigned BITS_PER_CYCLE = 2;
   localparam int unsigned STEPS          = 32 / BITS_PER_CYCLE;
   localparam int unsigned CNT_W          = $clog2(STEPS);

   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [32:0]      trial;

   // The partial remainder stays below the divisor, so 32 bits hold it.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial  = {rem_in, quo_in[31]};
         quo_in = {quo_in[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != '0);
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/pcgbg_datapath.sv =====
// Datapath: configuration registers, LCG state, shared 32x32 multiplier,
// output permutation and result register. Uses pcgbg_pkg and pcgbg_rem.
module pcgbg_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pcgbg_pkg::dp_cmd_type    cmd,
   output pcgbg_pkg::dp_status_type status,
   input  logic [63:0]              csr_wdata,
   input  logic [31:0]              req_limit,
   output logic [31:0]              rsp_value
);

   logic [63:0] seed_ff;
   logic [63:0] stream_ff;
   logic [63:0] state_ff;
   logic [63:0] inc_ff;
   logic [63:0] acc_ff;
   logic [63:0] prod_ff;
   logic [31:0] mul_a, mul_b;
   logic [31:0] bound_ff;
   logic [31:0] thr_ff;
   logic [31:0] draw_ff, draw_in;
   logic [31:0] value_ff;
   logic [31:0] div_dividend;
   logic        div_busy;
   logic [31:0] div_rem;
   logic [63:0] xsh;
   logic [63:0] rot_pair;

   // XSH-RR output function of the state before the step.
   always_comb begin
      xsh      = (state_ff >> 18) ^ state_ff;
      rot_pair = {xsh[58:27], xsh[58:27]} >> state_ff[63:59];
      draw_in  = rot_pair[31:0];
   end

   always_comb begin
      case (cmd.mul_sel)
         pcgbg_pkg::MUL_HL: begin
            mul_a = state_ff[63:32];
            mul_b = pcgbg_pkg::PCG_MULT_LO;
         end
         pcgbg_pkg::MUL_LH: begin
            mul_a = state_ff[31:0];
            mul_b = pcgbg_pkg::PCG_MULT_HI;
         end
         default: begin
            mul_a = state_ff[31:0];
            mul_b = pcgbg_pkg::PCG_MULT_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         stream_ff <= '0;
      end else begin
         if (cmd.cfg_wr_seed) begin
            seed_ff <= csr_wdata;
         end
         if (cmd.cfg_wr_stream) begin
            stream_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      case (cmd.acc_op)
         pcgbg_pkg::ACC_LOAD:   acc_ff <= prod_ff;
         pcgbg_pkg::ACC_ADD_HI: acc_ff[63:32] <= acc_ff[63:32] + prod_ff[31:0];
         default:               acc_ff <= acc_ff;
      endcase
      if (cmd.seed_init) begin
         state_ff <= '0;
         inc_ff   <= {stream_ff[62:0], 1'b1};
      end else if (cmd.seed_add) begin
         state_ff <= state_ff + seed_ff;
      end else if (cmd.commit) begin
         state_ff <= acc_ff + inc_ff;
      end
      if (cmd.commit) begin
         draw_ff <= draw_in;
      end
      if (cmd.bound_load) begin
         bound_ff <= req_limit;
      end
      if (cmd.thr_load) begin
         thr_ff <= div_rem;
      end
      if (cmd.out_load) begin
         case (cmd.out_sel)
            pcgbg_pkg::OUT_DRAW: value_ff <= draw_ff;
            pcgbg_pkg::OUT_REM:  value_ff <= div_rem;
            default:             value_ff <= '0;
         endcase
      end
   end

   assign div_dividend = (cmd.div_sel == pcgbg_pkg::DIV_DRAW) ? draw_ff : (32'd0 - bound_ff);

   pcgbg_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign status.limit_zero  = (req_limit == '0);
   assign status.draw_ge_thr = (draw_ff >= thr_ff);
   assign status.div_busy    = div_busy;
   assign rsp_value          = value_ff;

endmodule

// ===== src/pcgbg_controller.sv =====
// Controller state machine: seeding, LCG step sequence, rejection loop and
// result handshake. Uses pcgbg_pkg; drives the datapath through dp_cmd_type.
module pcgbg_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_mode,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                csr_valid,
   input  logic [pcgbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   output logic                                csr_ready,
   output pcgbg_pkg::dp_cmd_type               cmd,
   input  pcgbg_pkg::dp_status_type            status
);

   typedef enum logic [3:0] {
      ST_SEED_INIT,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_UPD,
      ST_SEED_ADD,
      ST_IDLE,
      ST_THR_START,
      ST_THR_WAIT,
      ST_CHECK,
      ST_REM_WAIT,
      ST_OUT
   } state_type;

   // Where the LCG step sequence returns to.
   typedef enum logic [1:0] {
      RET_SEED1,
      RET_SEED2,
      RET_DRAW,
      RET_BND
   } ret_type;

   state_type               state_ff;
   ret_type                 ret_ff;
   pcgbg_pkg::out_sel_type  out_sel_ff;
   logic                    rsp_valid_ff;
   logic                    csr_known;
   logic                    out_free;

   assign csr_known = (csr_index == pcgbg_pkg::CSR_SEED) ||
                      (csr_index == pcgbg_pkg::CSR_STREAM);
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd         = '0;
      cmd.out_sel = out_sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               cmd.cfg_wr_seed   = (csr_index == pcgbg_pkg::CSR_SEED);
               cmd.cfg_wr_stream = (csr_index == pcgbg_pkg::CSR_STREAM);
            end else if (req_valid) begin
               cmd.bound_load = 1'b1;
            end
         end
         ST_SEED_INIT: cmd.seed_init = 1'b1;
         ST_M0:        cmd.mul_sel = pcgbg_pkg::MUL_LL;
         ST_M1: begin
            cmd.mul_sel = pcgbg_pkg::MUL_HL;
            cmd.acc_op  = pcgbg_pkg::ACC_LOAD;
         end
         ST_M2: begin
            cmd.mul_sel = pcgbg_pkg::MUL_LH;
            cmd.acc_op  = pcgbg_pkg::ACC_ADD_HI;
         end
         ST_M3:        cmd.acc_op = pcgbg_pkg::ACC_ADD_HI;
         ST_UPD:       cmd.commit = 1'b1;
         ST_SEED_ADD:  cmd.seed_add = 1'b1;
         ST_THR_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = pcgbg_pkg::DIV_THR;
         end
         ST_THR_WAIT:  cmd.thr_load = !status.div_busy;
         ST_CHECK: begin
            cmd.div_start = status.draw_ge_thr;
            cmd.div_sel   = pcgbg_pkg::DIV_DRAW;
         end
         ST_REM_WAIT:  cmd.out_load = 1'b0;
         ST_OUT:       cmd.out_load = out_free;
         default:      cmd.out_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED_INIT;
         ret_ff       <= RET_SEED1;
         out_sel_ff   <= pcgbg_pkg::OUT_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  if (csr_known) begin
                     state_ff <= ST_SEED_INIT;
                  end
               end else if (req_valid) begin
                  if (!req_mode) begin
                     ret_ff   <= RET_DRAW;
                     state_ff <= ST_M0;
                  end else if (status.limit_zero) begin
                     out_sel_ff <= pcgbg_pkg::OUT_ZERO;
                     state_ff   <= ST_OUT;
                  end else begin
                     state_ff <= ST_THR_START;
                  end
               end
            end
            ST_SEED_INIT: begin
               ret_ff   <= RET_SEED1;
               state_ff <= ST_M0;
            end
            ST_M0: state_ff <= ST_M1;
            ST_M1: state_ff <= ST_M2;
            ST_M2: state_ff <= ST_M3;
            ST_M3: state_ff <= ST_UPD;
            ST_UPD: begin
               unique case (ret_ff)
                  RET_SEED1: state_ff <= ST_SEED_ADD;
                  RET_SEED2: state_ff <= ST_IDLE;
                  RET_DRAW: begin
                     out_sel_ff <= pcgbg_pkg::OUT_DRAW;
                     state_ff   <= ST_OUT;
                  end
                  default: state_ff <= ST_CHECK;
               endcase
            end
            ST_SEED_ADD: begin
               ret_ff   <= RET_SEED2;
               state_ff <= ST_M0;
            end
            ST_THR_START: state_ff <= ST_THR_WAIT;
            ST_THR_WAIT: begin
               if (!status.div_busy) begin
                  ret_ff   <= RET_BND;
                  state_ff <= ST_M0;
               end
            end
            ST_CHECK: begin
               if (status.draw_ge_thr) begin
                  state_ff <= ST_REM_WAIT;
               end else begin
                  state_ff <= ST_M0;
               end
            end
            ST_REM_WAIT: begin
               if (!status.div_busy) begin
                  out_sel_ff <= pcgbg_pkg::OUT_REM;
                  state_ff   <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/pcg32_bounded_generator_top.sv =====
// PCG-XSH-RR 64/32 generator with threshold-rejection bounded draws.
// A raw draw takes one LCG step and a zero bound takes none. A bounded draw runs
// the remainder unit twice, with one more LCG step per rejected draw. The LCG
// step runs on one shared 32x32 multiplier.
// One request is in flight at a time; the result register frees the input side.
// Reset and each write to a listed register reseed, busy until done, then ready.
module pcg32_bounded_generator_top (
   input  logic                              clock,
   input  logic                              reset,

   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [31:0]                       req_limit,

   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_value,

   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcgbg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                       csr_wdata
);

   // The controller sequences every multi-cycle operation; the datapath only
   // follows the command word and reports the few conditions that steer it.
   pcgbg_pkg::dp_cmd_type    cmd;
   pcgbg_pkg::dp_status_type status;

   // A bounded draw first computes the rejection threshold (2^32 - bound) mod
   // bound, then steps the LCG until a word at or above the threshold comes
   // out, and finally reduces that word modulo the bound. Each LCG step forms
   // the low 64 bits of state times the multiplier from three 32x32 partial
   // products, then adds the increment.
   pcgbg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pcgbg_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_wdata (csr_wdata),
      .req_limit (req_limit),
      .rsp_value (rsp_value)
   );

   // An accepted request always leaves the idle state, so the next word waits.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while block still idle");

   // A write to a listed register starts a reseed, which blocks requests.
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == pcgbg_pkg::CSR_SEED || csr_index == pcgbg_pkg::CSR_STREAM))
      |=> (req_stall && !csr_ready))
      else $error("configuration write did not start reseeding");

   // Requests are only taken when configuration writes could be taken too.
   assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> req_stall)
      else $error("request side open while block busy");

   // Coming out of reset the block is busy seeding.
   assert property (@(posedge clock)
      $fell(reset) |-> (req_stall && !csr_ready))
      else $error("block ready before reset seeding finished");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the PCG-XSH-RR 64/32 bounded generator.
// Holds a draw ledger class that predicts every result word and the tasks that drive the block.
// Depends on pcgbg_pkg and pcg32_bounded_generator_top.
module tb_top;

   // Width of the register index, as the block declares it.
   localparam int unsigned CSR_INDEX_W = pcgbg_pkg::CSR_INDEX_W;

   // Request modes as carried on req_mode.
   localparam bit MODE_RAW     = 1'b0;
   localparam bit MODE_BOUNDED = 1'b1;

   // The run is cut off after this many clock cycles. A correct run needs a
   // small fraction of it, even with every bounded draw rejecting often.
   localparam int LIMIT_CYCLES = 1_000_000;

   // Cycles to wait after the last result before a register write or the end.
   localparam int SETTLE_CYCLES = 64;

   // Length of the long receiver hold-off that backs up the block.
   localparam int HOLD_OFF_CYCLES = 400;

   // Random request words per randomized phase.
   localparam int PHASE_WORDS = 276;

   // The draw ledger keeps its own copy of the generator state and the
   // configuration, works out the result word of each accepted request,
   // and compares the words the block returns against them in order.
   class pcg_draw_ledger;
      bit [63:0] lcg_state;
      bit [63:0] lcg_incr;
      bit [63:0] seed_reg;
      bit [63:0] stream_reg;
      bit [31:0] expected_values[$];
      int        errors;

      function new();
         seed_reg   = '0;
         stream_reg = '0;
         errors     = 0;
         reseed();
      endfunction

      // One LCG step; the output word is permuted from the old state.
      function bit [31:0] next_raw_word();
         bit [63:0] old_state;
         bit [31:0] xs;
         bit [4:0]  rot;
         bit [4:0]  lrot;
         old_state = lcg_state;
         lcg_state = old_state * {pcgbg_pkg::PCG_MULT_HI, pcgbg_pkg::PCG_MULT_LO}
                     + lcg_incr;
         xs        = 32'(((old_state >> 18) ^ old_state) >> 27);
         rot       = old_state[63:59];
         lrot      = 5'd0 - rot;
         return (xs >> rot) | (xs << lrot);
      endfunction

      // Standard PCG seeding: state 0, one step, add the seed, one more step.
      function void reseed();
         bit [31:0] discard;
         lcg_incr  = {stream_reg[62:0], 1'b1};
         lcg_state = '0;
         discard   = next_raw_word();
         lcg_state = lcg_state + seed_reg;
         discard   = next_raw_word();
      endfunction

      function void write_register(bit [CSR_INDEX_W-1:0] index, bit [63:0] data);
         if (index == pcgbg_pkg::CSR_SEED) begin
            seed_reg = data;
            reseed();
         end else if (index == pcgbg_pkg::CSR_STREAM) begin
            stream_reg = data;
            reseed();
         end
      endfunction

      function void note_request(bit mode, bit [31:0] limit);
         bit [31:0] thr;
         bit [31:0] draw;
         if (mode == MODE_RAW) begin
            expected_values.push_back(next_raw_word());
         end else if (limit == 0) begin
            expected_values.push_back(32'd0);
         end else begin
            thr  = (32'd0 - limit) % limit;
            draw = next_raw_word();
            while (draw < thr) draw = next_raw_word();
            expected_values.push_back(draw % limit);
         end
      endfunction

      function void check_value(bit [31:0] value);
         bit [31:0] want;
         if (expected_values.size() == 0) begin
            errors++;
            $error("value: no word expected, actual %h", value);
            return;
         end
         want = expected_values.pop_front();
         if (value !== want) begin
            errors++;
            $error("value: expected %h, actual %h", want, value);
         end
      endfunction

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_mode;
   logic [31:0]            req_limit;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [31:0]            rsp_value;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [63:0]            csr_wdata;

   // Idling knobs for the current phase, in percent, and the long hold-off.
   int             sender_idle_pct;
   int             receiver_stall_pct;
   logic           hold_off;
   int             cycle_count;
   pcg_draw_ledger ledger;

   pcg32_bounded_generator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_limit (req_limit),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Result side. Every signal is sampled at the rising edge, before any
   // nonblocking update of that edge lands, so a word is taken exactly when
   // rsp_valid was high and our own rsp_stall was low. The stall for the
   // next cycle is then chosen at random, or held high during the hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_value(rsp_value);
      rsp_stall <= hold_off || ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Watchdog: a run that is still going at the limit has hung.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one request word and returns at the edge that accepts it. An
   // idle gap, when one is drawn, lowers valid first; back-to-back words
   // keep valid high and only change the payload, so valid never gets two
   // assignments in one step.
   task automatic send_word(input bit mode, input bit [31:0] limit);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_limit <= limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_request(mode, limit);
   endtask

   // Writes one configuration register. Valid is dropped and one more edge
   // passes, so a following write raises valid in a later step.
   task automatic write_csr(input bit [CSR_INDEX_W-1:0] index, input bit [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected word has come back, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random request words. Bounds lean toward small values, toward zero, toward
   // the largest values and toward just above 2^31 where rejection is most
   // frequent, with plenty of full-range words so every limit bit toggles.
   task automatic send_random_words(input int count);
      bit        mode;
      bit [31:0] limit;
      for (int n = 0; n < count; n++) begin
         mode = ($urandom_range(0, 9) < 6) ? MODE_BOUNDED : MODE_RAW;
         case ($urandom_range(0, 9))
            0: limit = 32'd0;
            1: limit = $urandom_range(1, 16);
            2, 3: limit = $urandom_range(1, 1000);
            4: limit = 32'h8000_0000 + $urandom_range(0, 255);
            5: limit = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: limit = $urandom;
         endcase
         send_word(mode, limit);
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_mode           = MODE_RAW;
      req_limit          = '0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      hold_off           = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      ledger             = new();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words against the reset seeding, with no idling. They cover
      // raw draws with any limit, the zero bound (twice, so a stray state
      // advance shows), a bound of one, powers of two, the largest bounds,
      // and bounds just above 2^31 where half the draws are rejected.
      send_word(MODE_RAW,     32'h0000_0000);
      send_word(MODE_RAW,     32'hFFFF_FFFF);
      send_word(MODE_BOUNDED, 32'h0000_0000);
      send_word(MODE_BOUNDED, 32'h0000_0000);
      send_word(MODE_BOUNDED, 32'h0000_0001);
      send_word(MODE_BOUNDED, 32'h0000_0002);
      send_word(MODE_BOUNDED, 32'h0000_0003);
      send_word(MODE_BOUNDED, 32'h0000_0007);
      send_word(MODE_BOUNDED, 32'hFFFF_FFFF);
      send_word(MODE_BOUNDED, 32'hFFFF_FFFE);
      send_word(MODE_BOUNDED, 32'h8000_0000);
      send_word(MODE_BOUNDED, 32'h8000_0001);
      send_word(MODE_BOUNDED, 32'h8000_0002);
      send_word(MODE_BOUNDED, 32'h5555_5555);
      send_word(MODE_BOUNDED, 32'hAAAA_AAAA);
      send_word(MODE_RAW,     32'h1234_5678);
      send_word(MODE_BOUNDED, 32'h7FFF_FFFF);
      send_word(MODE_BOUNDED, 32'd1000);
      send_word(MODE_RAW,     32'h0000_0000);
      send_word(MODE_BOUNDED, 32'h0001_0001);
      drain();

      // Both registers at all ones; the stream's top bit falls out of the
      // increment. An index past the register map must not reseed.
      write_csr(pcgbg_pkg::CSR_SEED,   64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(pcgbg_pkg::CSR_STREAM, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_INDEX_W'($urandom_range(2, 255)), {$urandom, $urandom});
      send_random_words(PHASE_WORDS);
      drain();

      // Sender idles before 46 words of a hundred.
      sender_idle_pct = 46;
      write_csr(pcgbg_pkg::CSR_SEED,   {$urandom, $urandom});
      write_csr(pcgbg_pkg::CSR_STREAM, 64'h0);
      send_random_words(PHASE_WORDS);
      drain();

      // Receiver stalls at random with a chance of 46 percent. A stream of only the top
      // bit gives the same increment as stream zero.
      sender_idle_pct    = 0;
      receiver_stall_pct = 46;
      write_csr(pcgbg_pkg::CSR_SEED,   64'h0);
      write_csr(pcgbg_pkg::CSR_STREAM, 64'h8000_0000_0000_0000);
      write_csr(CSR_INDEX_W'(8'hFF), 64'hFFFF_FFFF_FFFF_FFFF);
      send_random_words(PHASE_WORDS);
      drain();

      // Sender idles before 16 words of a hundred; receiver stalls at random with a chance of 16 percent.
      sender_idle_pct    = 16;
      receiver_stall_pct = 16;
      write_csr(pcgbg_pkg::CSR_STREAM, {$urandom, $urandom});
      write_csr(pcgbg_pkg::CSR_SEED,   {$urandom, $urandom});
      send_random_words(PHASE_WORDS);
      drain();

      // Back-pressure: the receiver holds off for a long stretch while the
      // sender keeps offering words, so the result register fills and the
      // block has to stall its request side.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_csr(pcgbg_pkg::CSR_SEED,   {$urandom, $urandom});
      write_csr(pcgbg_pkg::CSR_STREAM, {$urandom, $urandom});
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
         send_random_words(PHASE_WORDS);
      join
      drain();

      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/pcgbg_pkg.sv
src/pcgbg_rem.sv
src/pcgbg_datapath.sv
src/pcgbg_controller.sv
src/pcg32_bounded_generator_top.sv
sim/tb_top.sv
